/* hdl/pcsz_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the safety zone check.
package pcsz_pkg;

   localparam int unsigned LIMIT_W     = 31;
   localparam int unsigned DSQ_W       = 63;
   localparam int unsigned XB_W        = 32;
   localparam int unsigned FACTOR_W    = 17;
   localparam int unsigned ROOT_W      = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned CSR_IDX_W   = 4;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [FACTOR_W-1:0] FULL_SPEED   = 17'd65536;
   localparam logic [13:0]         NEAR_ZERO_SQ = 14'd4295;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_X     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Y     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Z     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONE_COS  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CRITICAL  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SLOWDOWN  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INV_BAND  = 4'd7;

   typedef struct packed {
      logic [63:0]        row_x;
      logic [63:0]        row_y;
      logic [63:0]        row_z;
      logic [31:0]        height_band;
      logic [15:0]        cone_cosine;
      logic [LIMIT_W-1:0] critical_limit;
      logic [LIMIT_W-1:0] slowdown_limit;
      logic [31:0]        inverse_band;
   } cfg_type;

   // One classified point handed from the front to the back.
   typedef struct packed {
      logic              keep;
      logic              fwd;
      logic              last;
      logic [XB_W-1:0]   xb;
      logic [DSQ_W-1:0]  dsq;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SQRT = 6'b000010,
      ST_CONE = 6'b000100,
      ST_TEST = 6'b001000,
      ST_FACT = 6'b010000,
      ST_DONE = 6'b100000
   } back_state_type;

endpackage

/* hdl/pcsz_if.sv */
`timescale 1ns / 1ps
// Channel interfaces: point words, result words and register writes.
interface pcsz_point_if #(parameter int unsigned COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic                          point_valid;
   logic                          forward;
   logic                          last;
   modport source (output valid, point_x, point_y, point_z, point_valid, forward, last,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, point_valid, forward, last,
                   output ready);
endinterface

interface pcsz_result_if;
   logic        valid;
   logic        ready;
   logic [16:0] factor;
   logic        stop;
   modport source (output valid, factor, stop, input ready);
   modport sink   (input valid, factor, stop, output ready);
endinterface

interface pcsz_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/pcsz_front.sv */
`timescale 1ns / 1ps
// Front end: accept points, transform to body frame, filter, square distance.
module pcsz_front
   import pcsz_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   pcsz_point_if.sink       req,
   input  cfg_type          cfg,
   input  queue_status_type qstat,
   output logic             push,
   output entry_type        push_entry
);

   localparam int unsigned CW = COORD_WIDTH;
   localparam int unsigned PW = CW + 16;
   localparam int unsigned BW = (CW + 4 > 33) ? CW + 4 : 33;
   localparam logic signed [CW-1:0] NZ_HI = CW'(66);
   localparam logic signed [CW-1:0] NZ_LO = -NZ_HI;

   logic en;

   // stage A: accepted word
   logic a_vld_ff, a_vld_in;
   logic signed [CW-1:0] a_px_ff, a_py_ff, a_pz_ff;
   logic a_ok_ff, a_fwd_ff, a_last_ff;

   // stage B: products
   logic b_vld_ff, b_vld_in;
   logic signed [PW-1:0] b_prod_ff [9];
   logic signed [PW-1:0] b_prod_in [9];
   logic b_ok_ff, b_ok_in, b_fwd_ff, b_last_ff;

   // stage C: body coordinates
   logic c_vld_ff, c_vld_in;
   logic signed [BW-1:0] c_xb_ff, c_yb_ff, c_zb_ff, c_xb_in, c_yb_in, c_zb_in;
   logic c_ok_ff, c_fwd_ff, c_last_ff;

   // stage D: squares
   logic d_vld_ff, d_vld_in;
   logic [61:0] d_sqx_ff, d_sqy_ff, d_sqx_in, d_sqy_in;
   logic signed [XB_W-1:0] d_xb_ff;
   logic d_ok_ff, d_ok_in, d_fwd_ff, d_last_ff;

   logic [61:0] lim_sq_ff, lim_sq_in;

   assign en        = !(d_vld_ff && qstat.full);
   assign req.ready = en;
   assign a_vld_in  = req.valid;
   assign b_vld_in  = a_vld_ff;
   assign c_vld_in  = b_vld_ff;
   assign d_vld_in  = c_vld_ff;
   assign lim_sq_in = 62'(cfg.slowdown_limit) * 62'(cfg.slowdown_limit);

   // near-zero planar extent on small coordinates
   logic [7:0]  nx8, ny8;
   logic [6:0]  nxa, nya;
   logic [13:0] nsq;
   logic        near;
   logic signed [15:0] w [9];

   always_comb begin
      nx8  = a_px_ff[7:0];
      ny8  = a_py_ff[7:0];
      nxa  = nx8[7] ? 7'(-nx8) : nx8[6:0];
      nya  = ny8[7] ? 7'(-ny8) : ny8[6:0];
      nsq  = 14'(nxa * nxa) + 14'(nya * nya);
      near = (a_px_ff > NZ_LO) && (a_px_ff < NZ_HI) && (a_py_ff > NZ_LO) &&
             (a_py_ff < NZ_HI) && (nsq < NEAR_ZERO_SQ);
      b_ok_in = a_ok_ff && !near;
      w[0] = cfg.row_x[15:0];  w[1] = cfg.row_x[31:16]; w[2] = cfg.row_x[47:32];
      w[3] = cfg.row_y[15:0];  w[4] = cfg.row_y[31:16]; w[5] = cfg.row_y[47:32];
      w[6] = cfg.row_z[15:0];  w[7] = cfg.row_z[31:16]; w[8] = cfg.row_z[47:32];
      for (int i = 0; i < 9; i++) begin
         unique case (i % 3)
            0:       b_prod_in[i] = PW'(w[i]) * PW'(a_px_ff);
            1:       b_prod_in[i] = PW'(w[i]) * PW'(a_py_ff);
            default: b_prod_in[i] = PW'(w[i]) * PW'(a_pz_ff);
         endcase
      end
   end

   function automatic logic signed [BW-1:0] floor_q14(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = p >>> 14;
      return {{(BW-CW-2){s[CW+1]}}, s[CW+1:0]};
   endfunction

   function automatic logic signed [BW-1:0] offset_q8(input logic [15:0] o);
      return {{(BW-24){o[15]}}, o, 8'b0};
   endfunction

   always_comb begin
      c_xb_in = floor_q14(b_prod_ff[0]) + floor_q14(b_prod_ff[1]) + floor_q14(b_prod_ff[2]) +
                offset_q8(cfg.row_x[63:48]);
      c_yb_in = floor_q14(b_prod_ff[3]) + floor_q14(b_prod_ff[4]) + floor_q14(b_prod_ff[5]) +
                offset_q8(cfg.row_y[63:48]);
      c_zb_in = floor_q14(b_prod_ff[6]) + floor_q14(b_prod_ff[7]) + floor_q14(b_prod_ff[8]) +
                offset_q8(cfg.row_z[63:48]);
   end

   // height band and box limits, then squares of the magnitudes
   logic signed [BW-1:0] lo, hi, lim;
   logic signed [BW-1:0] axw, ayw;
   logic [LIMIT_W-1:0]   ax, ay;
   always_comb begin
      lo  = offset_q8(cfg.height_band[15:0]);
      hi  = offset_q8(cfg.height_band[31:16]);
      lim = {{(BW-LIMIT_W){1'b0}}, cfg.slowdown_limit};
      axw = c_xb_ff[BW-1] ? -c_xb_ff : c_xb_ff;
      ayw = c_yb_ff[BW-1] ? -c_yb_ff : c_yb_ff;
      ax  = axw[LIMIT_W-1:0];
      ay  = ayw[LIMIT_W-1:0];
      d_sqx_in = 62'(ax) * 62'(ax);
      d_sqy_in = 62'(ay) * 62'(ay);
      d_ok_in  = c_ok_ff && !(c_zb_ff < lo) && !(c_zb_ff > hi) &&
                 !(c_xb_ff > lim) && !(c_xb_ff < -lim) &&
                 !(c_yb_ff > lim) && !(c_yb_ff < -lim);
   end

   logic [DSQ_W-1:0] dsq;
   always_comb begin
      dsq = DSQ_W'(d_sqx_ff) + DSQ_W'(d_sqy_ff);
      push_entry.keep = d_ok_ff && (dsq <= DSQ_W'(lim_sq_ff));
      push_entry.fwd  = d_fwd_ff;
      push_entry.last = d_last_ff;
      push_entry.xb   = d_xb_ff;
      push_entry.dsq  = dsq;
      // drop points that are filtered out and end nothing
      push = d_vld_ff && !qstat.full && (push_entry.keep || d_last_ff);
   end

   always_ff @(posedge clock) begin
      lim_sq_ff <= lim_sq_in;
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
      end
      if (en) begin
         a_px_ff   <= req.point_x;
         a_py_ff   <= req.point_y;
         a_pz_ff   <= req.point_z;
         a_ok_ff   <= req.point_valid;
         a_fwd_ff  <= req.forward;
         a_last_ff <= req.last;
         b_prod_ff <= b_prod_in;
         b_ok_ff   <= b_ok_in;
         b_fwd_ff  <= a_fwd_ff;
         b_last_ff <= a_last_ff;
         c_xb_ff   <= c_xb_in;
         c_yb_ff   <= c_yb_in;
         c_zb_ff   <= c_zb_in;
         c_ok_ff   <= b_ok_ff;
         c_fwd_ff  <= b_fwd_ff;
         c_last_ff <= b_last_ff;
         d_sqx_ff  <= d_sqx_in;
         d_sqy_ff  <= d_sqy_in;
         d_xb_ff   <= c_xb_ff[XB_W-1:0];
         d_ok_ff   <= d_ok_in;
         d_fwd_ff  <= c_fwd_ff;
         d_last_ff <= c_last_ff;
      end
   end

endmodule

/* hdl/pcsz_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified points between front and back.
module pcsz_queue
   import pcsz_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type qstat
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   always_comb begin
      qstat.full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      qstat.empty = (cnt_ff == '0);
      head        = mem_ff[rd_ff];
      wr_in       = push ? wr_ff + 1'b1 : wr_ff;
      rd_in       = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in      = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_entry;
   end

endmodule

/* hdl/pcsz_back.sv */
`timescale 1ns / 1ps
// Back end: square root, cone test, speed factor and result register.
module pcsz_back
   import pcsz_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  entry_type        head,
   input  queue_status_type qstat,
   output logic             pop,
   pcsz_result_if.source    rsp
);

   back_state_type state_ff, state_in;
   entry_type      cur_ff, cur_in;
   logic [63:0]    val_ff, val_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic signed [48:0] rhs_ff, rhs_in;
   logic [62:0]    prod_ff, prod_in;
   logic [FACTOR_W-1:0] minf_ff, minf_in;
   logic           stopped_ff, stopped_in;
   logic           rv_ff, rv_in;
   logic [FACTOR_W-1:0] rf_ff, rf_in;
   logic           rs_ff, rs_in;

   logic [ROOT_W+1:0]  rtry, trial;
   logic signed [48:0] lhs;
   logic               cone_ok;
   logic [46:0]        fraw;
   logic [FACTOR_W-1:0] fsat;
   logic               out_free;

   assign rsp.valid  = rv_ff;
   assign rsp.factor = rf_ff;
   assign rsp.stop   = rs_ff;

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      val_in     = val_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      cnt_in     = cnt_ff;
      rhs_in     = rhs_ff;
      prod_in    = prod_ff;
      minf_in    = minf_ff;
      stopped_in = stopped_ff;
      rv_in      = rv_ff && !rsp.ready;
      rf_in      = rf_ff;
      rs_in      = rs_ff;
      pop        = 1'b0;
      out_free   = !rv_ff || rsp.ready;

      rtry    = {rem_ff[ROOT_W-1:0], val_ff[63:62]};
      trial   = {root_ff, 2'b01};
      lhs     = 49'(signed'(cur_ff.xb)) <<< 15;
      cone_ok = cur_ff.fwd ? (lhs >= rhs_ff) : (lhs <= -rhs_ff);
      fraw    = prod_ff[62:16];
      fsat    = (fraw > 47'(FULL_SPEED)) ? FULL_SPEED : fraw[FACTOR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop     = 1'b1;
               cur_in  = head;
               val_in  = {1'b0, head.dsq};
               rem_in  = '0;
               root_in = '0;
               cnt_in  = '0;
               state_in = (head.keep && !stopped_ff) ? ST_SQRT : ST_DONE;
            end
         end
         ST_SQRT: begin
            // one root bit per cycle
            if (rtry >= trial) begin
               rem_in  = rtry - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rtry;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            val_in = {val_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) state_in = ST_CONE;
         end
         ST_CONE: begin
            rhs_in   = 49'(signed'({1'b0, root_ff})) * 49'(signed'(cfg.cone_cosine));
            state_in = ST_TEST;
         end
         ST_TEST: begin
            prod_in = 63'(root_ff - ROOT_W'(cfg.critical_limit)) * 63'(cfg.inverse_band);
            if (!cone_ok) begin
               state_in = ST_DONE;
            end else if (root_ff <= ROOT_W'(cfg.critical_limit)) begin
               stopped_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_FACT;
            end
         end
         ST_FACT: begin
            if (fsat < minf_ff) minf_in = fsat;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!cur_ff.last) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rv_in      = 1'b1;
               rf_in      = stopped_ff ? '0 : minf_ff;
               rs_in      = stopped_ff;
               minf_in    = FULL_SPEED;
               stopped_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         minf_ff    <= FULL_SPEED;
         stopped_ff <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         minf_ff    <= minf_in;
         stopped_ff <= stopped_in;
         rv_ff      <= rv_in;
      end
      cur_ff  <= cur_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      rhs_ff  <= rhs_in;
      prod_ff <= prod_in;
      rf_ff   <= rf_in;
      rs_ff   <= rs_in;
   end

endmodule

/* hdl/point_cloud_safety_zone_check_top.sv */
`timescale 1ns / 1ps
// Path: front stages A to D, then the queue, then for a kept point the back's 32-step root.
// Throughput: the front takes one word a cycle unless a full queue stalls it; the back
//   finishes each point, root iteration included, before it pops the next one.
// Filtered points that end nothing are dropped in the front and never enter the queue.
// Reset (synchronous, high): registers to their defaults, factor full speed, queue empty.
module point_cloud_safety_zone_check_top
   import pcsz_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   pcsz_point_if.sink    req,
   pcsz_result_if.source rsp,
   pcsz_csr_if.sink      csr
);

   // Register file: write only while the block is idle.
   cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_ROW_X:    cfg_in.row_x          = csr.data;
            REG_ROW_Y:    cfg_in.row_y          = csr.data;
            REG_ROW_Z:    cfg_in.row_z          = csr.data;
            REG_HEIGHT:   cfg_in.height_band    = csr.data[31:0];
            REG_CONE_COS: cfg_in.cone_cosine    = csr.data[15:0];
            REG_CRITICAL: cfg_in.critical_limit = csr.data[LIMIT_W-1:0];
            REG_SLOWDOWN: cfg_in.slowdown_limit = csr.data[LIMIT_W-1:0];
            REG_INV_BAND: cfg_in.inverse_band   = csr.data[31:0];
            default:      cfg_in = cfg_ff;  // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_x          <= 64'h4000_0000;
         cfg_ff.row_y          <= 64'h4000;
         cfg_ff.row_z          <= 64'h1000_0000;
         cfg_ff.height_band    <= 32'hFFFF_8000;
         cfg_ff.cone_cosine    <= 16'h0;
         cfg_ff.critical_limit <= 31'h0;
         cfg_ff.slowdown_limit <= 31'h1_0000;
         cfg_ff.inverse_band   <= 32'h1_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front classifies, queue decouples, back resolves the zone.
   queue_status_type qstat;
   logic             push, pop;
   entry_type        push_entry, head;

   pcsz_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock, .reset, .req, .cfg(cfg_ff), .qstat, .push, .push_entry
   );

   pcsz_queue u_queue (
      .clock, .reset, .push, .push_entry, .pop, .head, .qstat
   );

   pcsz_back u_back (
      .clock, .reset, .cfg(cfg_ff), .head, .qstat, .pop, .rsp
   );

endmodule

/* tb/sv/point_cloud_safety_zone_check_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking zone check bench: speed factor predictor, directed and random traffic.
import pcsz_pkg::*;

class zone_factor_scoreboard;
   typedef struct {
      logic [16:0] factor;
      logic        stop;
   } verdict_type;

   cfg_type     cfg;
   logic [16:0] floor_factor;
   logic        stopped;
   verdict_type expected_verdicts[$];
   int          mismatches;

   function new();
      cfg.row_x          = 64'h0000_0000_4000_0000;
      cfg.row_y          = 64'h0000_0000_0000_4000;
      cfg.row_z          = 64'h0000_0000_1000_0000;
      cfg.height_band    = 32'hFFFF_8000;
      cfg.cone_cosine    = 16'h0000;
      cfg.critical_limit = '0;
      cfg.slowdown_limit = 31'd65536;
      cfg.inverse_band   = 32'd65536;
      floor_factor       = FULL_SPEED;
      stopped            = 1'b0;
      mismatches         = 0;
   endfunction

   function void set_reg(logic [3:0] idx, logic [63:0] data);
      case (idx)
         REG_ROW_X:    cfg.row_x          = data;
         REG_ROW_Y:    cfg.row_y          = data;
         REG_ROW_Z:    cfg.row_z          = data;
         REG_HEIGHT:   cfg.height_band    = data[31:0];
         REG_CONE_COS: cfg.cone_cosine    = data[15:0];
         REG_CRITICAL: cfg.critical_limit = data[30:0];
         REG_SLOWDOWN: cfg.slowdown_limit = data[30:0];
         REG_INV_BAND: cfg.inverse_band   = data[31:0];
         default: ;
      endcase
   endfunction

   // Floored integer square root.
   function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bit_w;
      res   = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v   -= res + bit_w;
            res  = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   function longint body_coord(logic [63:0] row, longint px, longint py, longint pz);
      longint wx, wy, wz, off;
      wx  = longint'($signed(row[15:0]));
      wy  = longint'($signed(row[31:16]));
      wz  = longint'($signed(row[47:32]));
      off = longint'($signed(row[63:48]));
      return ((wx * px) >>> 14) + ((wy * py) >>> 14) + ((wz * pz) >>> 14) + off * 256;
   endfunction

   function void fold_point(longint px, longint py, longint pz, logic fwd);
      longint xb, yb, zb, lo, hi, lim, cosv, lhs, rhs;
      longint unsigned ax, ay, dsq, r, f;
      if (px > -66 && px < 66 && py > -66 && py < 66 && px * px + py * py < 4295) return;
      xb = body_coord(cfg.row_x, px, py, pz);
      yb = body_coord(cfg.row_y, px, py, pz);
      zb = body_coord(cfg.row_z, px, py, pz);
      lo = longint'($signed(cfg.height_band[15:0])) * 256;
      hi = longint'($signed(cfg.height_band[31:16])) * 256;
      if (zb < lo || zb > hi) return;
      lim = longint'(cfg.slowdown_limit);
      if (xb > lim || xb < -lim || yb > lim || yb < -lim) return;
      ax  = (xb < 0) ? -xb : xb;
      ay  = (yb < 0) ? -yb : yb;
      dsq = ax * ax + ay * ay;
      if (dsq > longint'(lim * lim)) return;
      r    = root_floor(dsq);
      cosv = longint'($signed(cfg.cone_cosine));
      lhs  = xb * 32768;
      rhs  = longint'(r) * cosv;
      if (fwd ? (lhs < rhs) : (lhs > -rhs)) return;
      if (r <= cfg.critical_limit) begin
         stopped = 1'b1;
         return;
      end
      if (r <= cfg.slowdown_limit) begin
         f = ((r - cfg.critical_limit) * cfg.inverse_band) >> 16;
         if (f > FULL_SPEED) f = FULL_SPEED;
         if (f < floor_factor) floor_factor = f[16:0];
      end
   endfunction

   function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic pv, logic fwd, logic lst);
      verdict_type v;
      if (pv && !stopped) fold_point(longint'(x), longint'(y), longint'(z), fwd);
      if (lst) begin
         v.factor = stopped ? 17'd0 : floor_factor;
         v.stop   = stopped;
         expected_verdicts.insert(expected_verdicts.size(), v);
         floor_factor = FULL_SPEED;
         stopped      = 1'b0;
      end
   endfunction

   function void check_result(logic [16:0] factor, logic stop);
      verdict_type v;
      if (expected_verdicts.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result word: factor %0d stop %0d", factor, stop);
         return;
      end
      v = expected_verdicts.pop_front();
      if (factor !== v.factor || stop !== v.stop) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result mismatch: factor exp %0d got %0d, stop exp %0d got %0d",
                     v.factor, factor, v.stop, stop);
      end
   endfunction

   function int pending();
      return expected_verdicts.size();
   endfunction
endclass

module point_cloud_safety_zone_check_top_tb;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 80;   // lets the pipeline empty after the last result
   localparam int HOLD_CYCLES    = 600;

   logic clock;
   logic reset;

   pcsz_point_if #(.COORD_WIDTH(32)) req_if();
   pcsz_result_if                    rsp_if();
   pcsz_csr_if                       csr_if();

   point_cloud_safety_zone_check_top #(.COORD_WIDTH(32)) u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr(csr_if)
   );

   zone_factor_scoreboard zone_sb = new();

   int  send_gap_pct;
   int  recv_stall_pct;
   int  points_taken;
   int  quiet_cycles;
   bit  hold_rsp;

   // Clock: 2 ns period.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Monitors: sample handshakes at the edge and feed the predictor.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            zone_sb.set_reg(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready) begin
            zone_sb.note_point(req_if.point_x, req_if.point_y, req_if.point_z,
                               req_if.point_valid, req_if.forward, req_if.last);
            points_taken++;
         end
         if (rsp_if.valid && rsp_if.ready)
            zone_sb.check_result(rsp_if.factor, rsp_if.stop);
      end
   end

   // Receiver: stall at random, or hold off entirely during a pressure stretch.
   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // Pressure: once traffic is flowing, starve the result side so the queue fills
   // and the block has to back-pressure its point input.
   initial begin
      hold_rsp = 1'b0;
      wait (points_taken >= 40);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Watchdog: count cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Write one register and hold until the word is taken.
   task automatic write_reg(logic [3:0] idx, logic [63:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // Offer one point word; insert random idle cycles first.
   task automatic send_point(int x, int y, int z, bit pv, bit fwd, bit lst);
      while ($urandom_range(99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.point_x     <= x;
      req_if.point_y     <= y;
      req_if.point_z     <= z;
      req_if.point_valid <= pv;
      req_if.forward     <= fwd;
      req_if.last        <= lst;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drain: drop valid, wait for every result, then let the pipeline settle.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (zone_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register sets: an identity mount, the extremes, odd corners and two random sets.
   task automatic apply_setting(int k);
      cfg_type c;
      logic [30:0] a, b;
      case (k)
         0: begin
            c.row_x = 64'h0000_0000_0000_4000;
            c.row_y = 64'h0000_0000_4000_0000;
            c.row_z = 64'h0000_4000_0000_0000;
            c.height_band = 32'h0200_FE00;          // -2 m .. +2 m
            c.cone_cosine = 16'h0000;
            c.critical_limit = 31'h0000_4CCC;       // 0.3 m
            c.slowdown_limit = 31'h0002_0000;       // 2 m
            c.inverse_band = 32'h0000_9696;         // 1 / 1.7 m
         end
         1: begin
            c.row_x = '1;
            c.row_y = '1;
            c.row_z = '1;
            c.height_band = 32'h7FFF_8000;
            c.cone_cosine = 16'h8000;
            c.critical_limit = '0;
            c.slowdown_limit = 31'h7FFF_FFFF;
            c.inverse_band = 32'hFFFF_FFFF;
         end
         2: begin
            // Critical not below slowdown, zero inverse band, narrow cone, offsets.
            c.row_x = 64'h0100_0000_0000_4000;
            c.row_y = 64'hFF00_0000_4000_0000;
            c.row_z = 64'h0000_4000_0000_0000;
            c.height_band = 32'h0100_FF00;
            c.cone_cosine = 16'h7FFF;
            c.critical_limit = 31'h0003_0000;
            c.slowdown_limit = 31'h0002_0000;
            c.inverse_band = 32'h0000_0000;
         end
         3: begin
            c.row_x = 64'h0000_0000_0000_C000;
            c.row_y = 64'h0000_0000_2000_2000;
            c.row_z = 64'h0080_4000_0000_0000;
            c.height_band = 32'h0300_FD00;
            c.cone_cosine = 16'h5A82;
            c.critical_limit = '0;
            c.slowdown_limit = 31'h0001_0000;
            c.inverse_band = 32'h0001_0000;
         end
         default: begin
            c.row_x = {$urandom, $urandom};
            c.row_y = {$urandom, $urandom};
            c.row_z = {$urandom, $urandom};
            c.height_band = $urandom;
            c.cone_cosine = 16'($urandom);
            a = 31'($urandom_range(32'h0004_0000));
            b = 31'($urandom_range(32'h0004_0000));
            c.critical_limit = (a < b) ? a : b;
            c.slowdown_limit = (a < b) ? b : a;
            c.inverse_band = $urandom_range(32'h0004_0000, 1);
         end
      endcase
      write_reg(REG_ROW_X, c.row_x);
      write_reg(REG_ROW_Y, c.row_y);
      write_reg(REG_ROW_Z, c.row_z);
      write_reg(REG_HEIGHT, {32'd0, c.height_band});
      write_reg(REG_CONE_COS, {48'd0, c.cone_cosine});
      write_reg(REG_CRITICAL, {33'd0, c.critical_limit});
      write_reg(REG_SLOWDOWN, {33'd0, c.slowdown_limit});
      write_reg(REG_INV_BAND, {32'd0, c.inverse_band});
      csr_if.valid <= 1'b0;
   endtask

   // Pick a coordinate: mostly near the slowdown ring, some tiny, some anywhere.
   function automatic int pick_coord(int span);
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(2 * span) - span;
      if (roll < 85) return $urandom_range(130) - 65;
      return $urandom;
   endfunction

   initial begin
      int span;
      int cloud_left;
      bit lst;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.point_x = '0;
      req_if.point_y = '0;
      req_if.point_z = '0;
      req_if.point_valid = 1'b0;
      req_if.forward = 1'b0;
      req_if.last    = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      send_gap_pct   = 27;
      recv_stall_pct = 54;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity mount, 0.3 m critical, 2 m slowdown.
      apply_setting(0);
      send_point(32'h0001_0000, 0, 0, 1'b0, 1'b1, 1'b1);          // invalid point ends cloud
      send_point(32'h0001_0000, 0, 0, 1'b1, 1'b1, 1'b1);          // 1 m ahead, slows
      send_point(10, 10, 0, 1'b1, 1'b1, 1'b1);                    // near-zero extent
      send_point(32'h0000_1999, 0, 0, 1'b1, 1'b1, 1'b1);          // inside critical
      send_point(32'h0000_1999, 0, 0, 1'b1, 1'b1, 1'b0);          // latch stop...
      send_point(32'h0001_8000, 0, 0, 1'b1, 1'b1, 1'b0);          // ...then ignored
      send_point(32'h0001_0000, 0, 0, 1'b1, 1'b1, 1'b1);
      send_point(-32'sh0001_0000, 0, 0, 1'b1, 1'b0, 1'b1);        // backward cone
      send_point(-32'sh0001_0000, 0, 0, 1'b1, 1'b1, 1'b1);        // behind, forward cone
      send_point(0, 32'h0001_0000, 0, 1'b1, 1'b1, 1'b1);          // on the cone edge
      send_point(32'h0001_0000, 0, 32'h0003_0000, 1'b1, 1'b1, 1'b1); // above band
      send_point(32'h0003_0000, 0, 0, 1'b1, 1'b1, 1'b1);          // beyond slowdown
      send_point(32'h0002_0000, 0, 0, 1'b1, 1'b1, 1'b1);          // exactly on slowdown
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 1'b1);
      send_point(32'h0000_8000, 32'h0000_8000, 0, 1'b1, 1'b1, 1'b0);
      send_point(32'h0001_4000, -32'sh0000_4000, 0, 1'b1, 1'b1, 1'b1); // minimum of two
      drain();

      // Random: six segments, two per idling profile, a new register set each.
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin send_gap_pct = 27; recv_stall_pct = 54; end
            1: begin send_gap_pct = 54; recv_stall_pct = 27; end
            default: begin send_gap_pct = 0; recv_stall_pct = 0; end
         endcase
         apply_setting(seg);
         span = (seg == 1) ? 32'h7FFF_FFFF : 32'h0002_8000;
         cloud_left = $urandom_range(6, 1);
         for (int n = 0; n < 75; n++) begin
            cloud_left--;
            lst = (cloud_left == 0) || (n == 74);
            send_point(pick_coord(span), pick_coord(span),
                       ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h6_0000) - 32'h3_0000,
                       $urandom_range(9) != 0, $urandom_range(1), lst);
            if (cloud_left == 0) cloud_left = $urandom_range(6, 1);
         end
         drain();
      end

      if (zone_sb.mismatches == 0 && zone_sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

/* sim.f */
hdl/pcsz_pkg.sv
hdl/pcsz_if.sv
hdl/pcsz_front.sv
hdl/pcsz_queue.sv
hdl/pcsz_back.sv
hdl/point_cloud_safety_zone_check_top.sv
tb/sv/point_cloud_safety_zone_check_top_tb.sv
